// ===== rtl/gcs_pkg.sv =====
// ============================================================================
// gcs_pkg
// Shared widths, operation codes and the word types that pass between the
// port-facing top level and the query sequencer.
// ============================================================================
package gcs_pkg;

    // Fixed field widths of the item and result words
    localparam int OP_W     = 2;
    localparam int VIDX_W   = 6;
    localparam int CNT_W    = 7;
    localparam int PCOLOR_W = 24;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD_EDGE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_COLOR = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

    // One input word
    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [VIDX_W-1:0]   vertex_a;
        logic [VIDX_W-1:0]   vertex_b;
        logic                has_color;
        logic [PCOLOR_W-1:0] color_value;
    } t_cmd;

    // One result word
    typedef struct packed {
        logic                coloring_ok;
        logic [PCOLOR_W-1:0] chosen_color;
    } t_result;

endpackage

// ===== rtl/gcs_ram.sv =====
// ============================================================================
// gcs_ram
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ============================================================================
module gcs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gcs_seq.sv =====
// ============================================================================
// gcs_seq
// Sequencer around the adjacency RAM and the color RAM. Clears both after
// reset, runs read-modify-write for edge inserts, and walks the color RAM
// for queries: a neighbor check of the queried color, a pass over all
// colored vertices for the smallest free used color, and a fallback search
// for the smallest color nobody holds.
// ============================================================================
module gcs_seq import gcs_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int COLOR_BITS   = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_vertex_count,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_busy,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ready
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int ENT_W = COLOR_BITS + 1;

    localparam logic [VW-1:0]           LAST_ROW  = VW'(MAX_VERTICES - 1);
    localparam logic [COLOR_BITS-1:0]   COLOR_MAX = '1;
    localparam logic [MAX_VERTICES-1:0] ONE_ROW   = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    // Sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_EDGE_RDA = 4'd2;
    localparam logic [3:0] S_EDGE_WRA = 4'd3;
    localparam logic [3:0] S_EDGE_RDB = 4'd4;
    localparam logic [3:0] S_EDGE_WRB = 4'd5;
    localparam logic [3:0] S_SET      = 4'd6;
    localparam logic [3:0] S_QRY_RD   = 4'd7;
    localparam logic [3:0] S_QRY_LD   = 4'd8;
    localparam logic [3:0] S_SCAN     = 4'd9;
    localparam logic [3:0] S_OUT_RD   = 4'd10;
    localparam logic [3:0] S_OUT_CHK  = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    // Purpose of the current scan
    localparam logic [1:0] P_CHECK = 2'd0;
    localparam logic [1:0] P_OUTER = 2'd1;
    localparam logic [1:0] P_FREE  = 2'd2;

    logic [3:0]              r_state;
    logic [VW-1:0]           r_clr;
    logic [VIDX_W-1:0]       r_a;
    logic [VIDX_W-1:0]       r_b;
    logic                    r_a_ok;
    logic                    r_has;
    logic [COLOR_BITS-1:0]   r_cval;
    logic [MAX_VERTICES-1:0] r_adj_row;
    logic [1:0]              r_phase;
    logic                    r_all;
    logic [COLOR_BITS-1:0]   r_cand;
    logic [CNT_W-1:0]        r_j;
    logic                    r_pv;
    logic [VW-1:0]           r_pj;
    logic [CNT_W-1:0]        r_i;
    logic                    r_found;
    logic [COLOR_BITS-1:0]   r_best;
    logic                    r_res_ok;

    logic                    adj_we;
    logic [VW-1:0]           adj_waddr;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic [VW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    col_we;
    logic [VW-1:0]           col_waddr;
    logic [ENT_W-1:0]        col_wdata;
    logic [VW-1:0]           col_raddr;
    logic [ENT_W-1:0]        col_rdata;

    logic                           col_colored;
    logic [COLOR_BITS-1:0]          col_color;
    logic [CNT_W-1:0]               scan_n;
    logic [VW-1:0]                  a_addr;
    logic [VW-1:0]                  b_addr;
    logic                           cmd_a_ok;
    logic                           cmd_b_ok;
    logic [COLOR_BITS+PCOLOR_W-1:0] cval_wide;
    logic [COLOR_BITS+PCOLOR_W-1:0] best_wide;
    logic                           scan_hit;
    logic                           scan_end;
    logic [COLOR_BITS-1:0]          cand_inc;
    logic                           cand_more;

    // Memories: adjacency rows and {colored, color} entries
    gcs_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    gcs_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (ENT_W)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    // Decode memory data and item fields
    assign col_colored = col_rdata[COLOR_BITS];
    assign col_color   = col_rdata[COLOR_BITS-1:0];
    assign a_addr      = VW'(r_a);
    assign b_addr      = VW'(r_b);
    assign cmd_a_ok    = 32'(i_cmd.vertex_a) < MAX_VERTICES;
    assign cmd_b_ok    = 32'(i_cmd.vertex_b) < MAX_VERTICES;
    assign cval_wide   = {{COLOR_BITS{1'b0}}, i_cmd.color_value};
    assign best_wide   = {{PCOLOR_W{1'b0}}, r_best};

    // Clamp the scanned vertex count to the storage depth
    assign scan_n = (32'(i_vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                         : i_vertex_count;

    // Scan compare on the entry read in the previous cycle
    assign scan_hit = r_pv && (r_all || r_adj_row[r_pj]) && col_colored &&
                      (col_color == r_cand);
    assign scan_end = scan_hit || (!r_pv && (r_j >= scan_n));

    // Next fallback candidate and whether the search may go on
    assign cand_inc  = r_cand + 1'b1;
    assign cand_more = (cand_inc != COLOR_MAX) &&
                       ({{CNT_W{1'b0}}, cand_inc} <= {{COLOR_BITS{1'b0}}, scan_n});

    // Memory port control; each access of a row finishes before the next
    // access to any row starts, so no forwarding is needed
    always_comb begin
        adj_we    = 1'b0;
        adj_waddr = a_addr;
        adj_wdata = adj_rdata;
        adj_raddr = a_addr;
        col_we    = 1'b0;
        col_waddr = a_addr;
        col_wdata = {r_has, r_cval};
        col_raddr = a_addr;
        unique case (r_state)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                adj_wdata = '0;
                col_we    = 1'b1;
                col_waddr = r_clr;
                col_wdata = '0;
            end
            S_EDGE_WRA: begin
                adj_we    = 1'b1;
                adj_wdata = adj_rdata | (ONE_ROW << r_b);
            end
            S_EDGE_RDB: begin
                adj_raddr = b_addr;
            end
            S_EDGE_WRB: begin
                adj_we    = 1'b1;
                adj_waddr = b_addr;
                adj_wdata = adj_rdata | (ONE_ROW << r_a);
            end
            S_SET: begin
                col_we = 1'b1;
            end
            S_SCAN: begin
                col_raddr = VW'(r_j);
            end
            S_OUT_RD: begin
                col_raddr = VW'(r_i);
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pv     <= 1'b0;
            r_found  <= 1'b0;
            r_res_ok <= 1'b0;
        end else begin
            unique case (r_state)
                // Sweep both memories once after reset
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                // Take a word and dispatch on its operation
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_a      <= i_cmd.vertex_a;
                        r_b      <= i_cmd.vertex_b;
                        r_a_ok   <= cmd_a_ok;
                        r_has    <= i_cmd.has_color;
                        r_cval   <= cval_wide[COLOR_BITS-1:0];
                        r_res_ok <= 1'b0;
                        unique case (i_cmd.operation)
                            OP_ADD_EDGE:
                                r_state <= (cmd_a_ok && cmd_b_ok) ? S_EDGE_RDA : S_IDLE;
                            OP_SET_COLOR:
                                r_state <= cmd_a_ok ? S_SET : S_IDLE;
                            OP_QUERY:
                                r_state <= S_QRY_RD;
                            default:
                                r_state <= S_IDLE;
                        endcase
                    end
                end
                // Edge insert: read-modify-write row a, then row b
                S_EDGE_RDA: r_state <= S_EDGE_WRA;
                S_EDGE_WRA: r_state <= S_EDGE_RDB;
                S_EDGE_RDB: r_state <= S_EDGE_WRB;
                S_EDGE_WRB: r_state <= S_IDLE;
                S_SET:      r_state <= S_IDLE;
                // Query: fetch the row and color of the queried vertex
                S_QRY_RD:   r_state <= S_QRY_LD;
                S_QRY_LD: begin
                    r_adj_row <= r_a_ok ? adj_rdata : '0;
                    r_j       <= '0;
                    r_pv      <= 1'b0;
                    r_i       <= '0;
                    r_found   <= 1'b0;
                    if (r_a_ok && col_colored) begin
                        r_cand  <= col_color;
                        r_all   <= 1'b0;
                        r_phase <= P_CHECK;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_OUT_RD;
                    end
                end
                // Walk the color memory looking for a holder of r_cand
                S_SCAN: begin
                    r_pj <= VW'(r_j);
                    if (scan_end) begin
                        r_j  <= '0;
                        r_pv <= 1'b0;
                        priority case (r_phase)
                            P_CHECK: begin
                                if (!scan_hit) begin
                                    r_res_ok <= 1'b1;
                                    r_best   <= '0;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_OUT_RD;
                                end
                            end
                            P_OUTER: begin
                                if (!scan_hit) begin
                                    r_best  <= r_cand;
                                    r_found <= 1'b1;
                                end
                                r_i     <= r_i + 1'b1;
                                r_state <= S_OUT_RD;
                            end
                            default: begin
                                if (!scan_hit) begin
                                    r_best  <= r_cand;
                                    r_state <= S_DONE;
                                end else if (cand_more) begin
                                    r_cand <= cand_inc;
                                end else begin
                                    r_best  <= COLOR_MAX;
                                    r_state <= S_DONE;
                                end
                            end
                        endcase
                    end else begin
                        // Advance the read pointer up to the scan limit
                        r_pv <= r_j < scan_n;
                        if (r_j < scan_n) begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                // Next used color to try, or fall back to a free color
                S_OUT_RD: begin
                    if (r_i >= scan_n) begin
                        if (r_found) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cand  <= '0;
                            r_all   <= 1'b1;
                            r_phase <= P_FREE;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_OUT_CHK;
                    end
                end
                S_OUT_CHK: begin
                    if (!col_colored || (r_found && (col_color >= r_best))) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_cand  <= col_color;
                        r_all   <= 1'b0;
                        r_phase <= P_OUTER;
                        r_state <= S_SCAN;
                    end
                end
                // Hold the result until the output stage takes it
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy                = r_state != S_IDLE;
    assign o_res_valid           = r_state == S_DONE;
    assign o_res.coloring_ok     = r_res_ok;
    assign o_res.chosen_color    = best_wide[PCOLOR_W-1:0];

`ifndef SYNTHESIS
    // An edge insert goes straight to its row read or is dropped
    a_edge_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_valid && !o_busy && i_cmd.operation == OP_ADD_EDGE) |=>
        (r_state == S_EDGE_RDA || r_state == S_IDLE))
        else $error("edge insert dispatched wrongly");

    // An ok result carries no suggested color
    a_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.coloring_ok) |-> (o_res.chosen_color == '0))
        else $error("ok result with nonzero color");

    // A compared entry always lies below the scan limit
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pv) |-> (32'(r_pj) < 32'(scan_n)))
        else $error("scan compared an entry beyond the limit");

    // A waiting result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("result dropped or changed before it was taken");
`endif

endmodule

// ===== rtl/graph_color_selector.sv =====
// ============================================================================
// graph_color_selector
// Greedy color selector over a stored undirected graph, with an APB register
// for the scanned vertex count and a registered result stage.
// ============================================================================
// After reset the block clears every row of its adjacency and color memories
// with o_in_stall high; register writes are taken during that time. It then
// works on one word at a time: an edge insert does two read-modify-writes of
// adjacency rows, a color write one write of the color memory, and an unknown
// operation nothing. A query walks the color memory one entry per cycle
// through its single read port, over n = min(vertex_count, MAX_VERTICES)
// entries per pass: a check of a colored queried vertex's color among the
// neighbors, then if needed passes over the used colors, and when no used
// color fits, a search for an unheld color. The result sits in an output
// register, so the next word is taken while it waits.
// ============================================================================
module graph_color_selector import gcs_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int COLOR_BITS   = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [VIDX_W-1:0]   i_vertex_a,
    input  logic [VIDX_W-1:0]   i_vertex_b,
    input  logic                i_has_color,
    input  logic [PCOLOR_W-1:0] i_color_value,
    // Output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_coloring_ok,
    output logic [PCOLOR_W-1:0] o_chosen_color
);

    localparam int               APB_DATA_W       = 32;
    localparam int               REG_IDX_BIT      = 2;
    localparam logic             REG_VERTEX_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] VCOUNT_RESET     = 7'd64;

    logic [CNT_W-1:0] r_vertex_count;
    logic             r_out_valid;
    t_result          r_out;

    t_cmd             cmd;
    logic             seq_busy;
    logic             res_valid;
    t_result          res;
    logic             res_ready;
    logic             cfg_wr;

    // Register write and read decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[REG_IDX_BIT] == REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (cfg_wr) begin
            r_vertex_count <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[REG_IDX_BIT] == REG_VERTEX_COUNT) begin
            prdata = {{(APB_DATA_W-CNT_W){1'b0}}, r_vertex_count};
        end
    end

    // Pack the input word
    assign cmd.operation   = i_operation;
    assign cmd.vertex_a    = i_vertex_a;
    assign cmd.vertex_b    = i_vertex_b;
    assign cmd.has_color   = i_has_color;
    assign cmd.color_value = i_color_value;

    gcs_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .COLOR_BITS   (COLOR_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vertex_count (r_vertex_count),
        .i_cmd_valid    (i_in_valid),
        .i_cmd          (cmd),
        .o_busy         (seq_busy),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_ready    (res_ready)
    );

    assign o_in_stall = seq_busy;

    // Output register: load when empty or being drained
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_coloring_ok  = r_out.coloring_ok;
    assign o_chosen_color = r_out.chosen_color;

endmodule

// ===== verif/tb_graph_color_selector.sv =====
// ============================================================================
// tb_graph_color_selector
// Self-checking bench for the greedy graph color selector. A queue of edge,
// color and query words feeds a clocked driver; a clocked monitor tracks the
// graph on every accepted word, predicts each query answer and checks it
// against the output channel. The vertex count register is swept through
// several settings, extremes included, with random idling on both channels.
// ============================================================================
module tb_graph_color_selector;
    import gcs_pkg::*;

    localparam int              NUM_VERTS      = 64;
    localparam int              SETTLE_CYCLES  = 16;
    localparam int              CYCLE_LIMIT    = 4000000;
    localparam logic [OP_W-1:0] OP_RESERVED    = 2'd3;
    localparam logic [2:0]      REG_VERT_COUNT = 3'd0;
    localparam logic [23:0]     TOP_COLOR      = 24'hFFFFFF;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // Register port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Input and output channels
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    logic [OP_W-1:0]     i_operation   = '0;
    logic [VIDX_W-1:0]   i_vertex_a    = '0;
    logic [VIDX_W-1:0]   i_vertex_b    = '0;
    logic                i_has_color   = 1'b0;
    logic [PCOLOR_W-1:0] i_color_value = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    logic                o_coloring_ok;
    logic [PCOLOR_W-1:0] o_chosen_color;

    graph_color_selector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_vertex_a     (i_vertex_a),
        .i_vertex_b     (i_vertex_b),
        .i_has_color    (i_has_color),
        .i_color_value  (i_color_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_coloring_ok  (o_coloring_ok),
        .o_chosen_color (o_chosen_color)
    );

    // Shadow graph kept in step with every accepted word
    logic [NUM_VERTS-1:0] graph_adj     [NUM_VERTS];
    logic [23:0]          graph_color   [NUM_VERTS];
    logic                 graph_colored [NUM_VERTS];
    logic [CNT_W-1:0]     graph_count;

    t_cmd    cmd_backlog[$];
    t_result answers_due[$];

    int  issued_cnt  = 0;
    int  taken_cnt   = 0;
    int  answers_cnt = 0;
    int  ok_cnt      = 0;
    int  err_cnt     = 0;
    int  cycle_cnt   = 0;
    int  setting_cnt = 1;
    bit  idle_on     = 1'b1;

    function automatic t_cmd make_cmd(input logic [OP_W-1:0] op, input int a, input int b,
                                      input bit has, input logic [23:0] color);
        t_cmd c;
        c.operation   = op;
        c.vertex_a    = a[VIDX_W-1:0];
        c.vertex_b    = b[VIDX_W-1:0];
        c.has_color   = has;
        c.color_value = color;
        return c;
    endfunction

    // True when a colored neighbor of q below the scan limit holds color c
    function automatic bit neighbor_has(input int q, input logic [23:0] c, input int n);
        for (int i = 0; i < n; i++) begin
            if (graph_adj[q][i] && graph_colored[i] && graph_color[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit color_held(input logic [23:0] c, input int n);
        for (int i = 0; i < n; i++) begin
            if (graph_colored[i] && graph_color[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one word to the shadow graph; return 1 with the answer for a query
    function automatic bit graph_apply(input t_cmd c, output t_result r);
        int          a;
        int          b;
        int          n;
        bit          found;
        logic [23:0] best;
        a = c.vertex_a;
        b = c.vertex_b;
        n = (graph_count > NUM_VERTS) ? NUM_VERTS : graph_count;
        r = '0;
        case (c.operation)
            OP_ADD_EDGE: begin
                graph_adj[a][b] = 1'b1;
                graph_adj[b][a] = 1'b1;
                return 1'b0;
            end
            OP_SET_COLOR: begin
                graph_colored[a] = c.has_color;
                if (c.has_color) graph_color[a] = c.color_value;
                return 1'b0;
            end
            OP_QUERY: begin
                if (graph_colored[a] && !neighbor_has(a, graph_color[a], n)) begin
                    r.coloring_ok = 1'b1;
                    return 1'b1;
                end
                // Smallest used color that no neighbor holds
                found = 1'b0;
                best  = '0;
                for (int i = 0; i < n; i++) begin
                    if (graph_colored[i] && !(found && graph_color[i] >= best) &&
                        !neighbor_has(a, graph_color[i], n)) begin
                        best  = graph_color[i];
                        found = 1'b1;
                    end
                end
                // Else smallest color nobody holds, saturating at the top
                if (!found) begin
                    best = TOP_COLOR;
                    for (int k = 0; k <= n; k++) begin
                        if (!color_held(k[23:0], n)) begin
                            best = k[23:0];
                            break;
                        end
                    end
                end
                r.chosen_color = best;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int pick_vertex(input int hi);
        if ($urandom_range(99) < 80) return $urandom_range(hi, 0);
        return $urandom_range(NUM_VERTS - 1, 0);
    endfunction

    // Random word biased toward vertices in scan range and colliding colors
    function automatic t_cmd random_cmd(input int span);
        t_cmd c;
        int   hi;
        int   roll;
        hi   = (span < 1) ? 0 : span - 1;
        roll = $urandom_range(99);
        c.operation = (roll < 30) ? OP_ADD_EDGE : (roll < 63) ? OP_SET_COLOR :
                      (roll < 95) ? OP_QUERY : OP_RESERVED;
        c.vertex_a  = VIDX_W'(pick_vertex(hi));
        c.vertex_b  = (c.operation == OP_ADD_EDGE) ? VIDX_W'(pick_vertex(hi)) :
                      VIDX_W'($urandom_range(NUM_VERTS - 1, 0));
        c.has_color = ($urandom_range(99) < 85);
        roll = $urandom_range(99);
        c.color_value = (roll < 70) ? 24'($urandom_range(7)) :
                        (roll < 85) ? 24'($urandom) :
                        (roll < 92) ? TOP_COLOR : 24'($urandom_range(7)) + 24'hFFFFF8;
        return c;
    endfunction

    // Two-phase register access; returns read data
    task automatic reg_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_vertex_count(input int cnt);
        logic [31:0] rd;
        reg_access(1'b1, REG_VERT_COUNT, 32'(cnt), rd);
        graph_count = cnt[CNT_W-1:0];
        reg_access(1'b0, REG_VERT_COUNT, '0, rd);
        if (rd !== {25'd0, graph_count}) begin
            $display("%0t vertex_count readback: expected %0d, actual %0d",
                     $time, graph_count, rd);
            err_cnt++;
        end
    endtask

    // Hold until every word is taken and answered, then let the block go idle
    task automatic drain();
        while (cmd_backlog.size() != 0 || taken_cnt != issued_cnt ||
               answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: present the next word, hold it while stalled
    always @(negedge i_clk) begin : drive_words
        t_cmd nxt;
        if (i_in_valid && taken_cnt != issued_cnt) begin
            // hold the stalled word
        end else if (i_rst_n && cmd_backlog.size() != 0 &&
                     !(idle_on && $urandom_range(99) < 16)) begin
            nxt = cmd_backlog.pop_front();
            i_in_valid    <= 1'b1;
            i_operation   <= nxt.operation;
            i_vertex_a    <= nxt.vertex_a;
            i_vertex_b    <= nxt.vertex_b;
            i_has_color   <= nxt.has_color;
            i_color_value <= nxt.color_value;
            issued_cnt++;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99) < 16);
    end

    // Monitor: check answers, then predict for the word taken at this edge
    always @(posedge i_clk) begin : watch_words
        t_result want;
        t_result fresh;
        t_cmd    seen;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                answers_cnt++;
                if (o_coloring_ok) ok_cnt++;
                if (answers_due.size() == 0) begin
                    $display("%0t unexpected answer: ok %0b color %0d", $time,
                             o_coloring_ok, o_chosen_color);
                    err_cnt++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_coloring_ok !== want.coloring_ok) begin
                        $display("%0t coloring_ok: expected %0b, actual %0b", $time,
                                 want.coloring_ok, o_coloring_ok);
                        err_cnt++;
                    end
                    if (o_chosen_color !== want.chosen_color) begin
                        $display("%0t chosen_color: expected %0d, actual %0d", $time,
                                 want.chosen_color, o_chosen_color);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                seen.operation   = i_operation;
                seen.vertex_a    = i_vertex_a;
                seen.vertex_b    = i_vertex_b;
                seen.has_color   = i_has_color;
                seen.color_value = i_color_value;
                if (graph_apply(seen, fresh)) answers_due.push_back(fresh);
                taken_cnt++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t watchdog expired with %0d answers outstanding", $time,
                     answers_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sequence: reset, directed words, then random phases per vertex count
    initial begin : stimulus
        int phase_cnt  [7] = '{8, 1, 0, 127, 3, 16, 64};
        int phase_words[7] = '{32, 8, 6, 10, 18, 28, 15};
        int span;
        for (int i = 0; i < NUM_VERTS; i++) begin
            graph_adj[i]     = '0;
            graph_color[i]   = '0;
            graph_colored[i] = 1'b0;
        end
        graph_count = 7'd64;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty graph, top color, extreme edge, self edge, reserved code
        cmd_backlog.push_back(make_cmd(OP_QUERY,     0,  0,  0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 0,  63, 1, TOP_COLOR));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     0,  63, 1, TOP_COLOR));
        cmd_backlog.push_back(make_cmd(OP_ADD_EDGE,  0,  63, 0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 63, 0,  1, TOP_COLOR));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     63, 0,  0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_ADD_EDGE,  5,  5,  1, 24'hAAAAAA));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 5,  42, 1, 24'd3));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     5,  21, 0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 63, 0,  0, 24'hABCDEF));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     63, 0,  0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_RESERVED,  63, 63, 1, TOP_COLOR));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     0,  0,  0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_ADD_EDGE,  62, 63, 0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 62, 0,  1, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 1,  0,  1, 24'd1));
        cmd_backlog.push_back(make_cmd(OP_ADD_EDGE,  1,  62, 0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     62, 0,  0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     1,  0,  0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 42, 21, 1, 24'h555555));
        cmd_backlog.push_back(make_cmd(OP_SET_COLOR, 1,  0,  1, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     1,  0,  0, 24'd0));
        cmd_backlog.push_back(make_cmd(OP_QUERY,     42, 0,  0, 24'd0));
        drain();

        // Random phases; the vertex-count 16 phase runs with no idling
        for (int p = 0; p < 7; p++) begin
            set_vertex_count(phase_cnt[p]);
            setting_cnt++;
            idle_on = (phase_cnt[p] != 16);
            span    = (phase_cnt[p] > NUM_VERTS) ? NUM_VERTS : phase_cnt[p];
            for (int k = 0; k < phase_words[p]; k++) cmd_backlog.push_back(random_cmd(span));
            drain();
        end

        $display("Sent %0d words across %0d vertex-count settings (0 and 127 included).",
                 taken_cnt, setting_cnt);
        $display("Checked %0d query answers, %0d of them reporting a valid coloring.",
                 answers_cnt, ok_cnt);
        if (err_cnt == 0 && answers_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
